FILE: design/memac_pkg.sv
// ----------------------------------------------------------------------------
// memac_pkg
// Shared widths, operation codes and types for the matrix element MAC core.
// ----------------------------------------------------------------------------
package memac_pkg;

   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int VAL_W  = 16;
   localparam int SUM_W  = 38;
   localparam int SIZE_W = 7;
   // compare width, holds any size in use up to the largest dimension
   localparam int CMP_W  = 9;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef logic        [OP_W-1:0]   op_type;
   typedef logic        [IDX_W-1:0]  idx_type;
   typedef logic signed [VAL_W-1:0]  value_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic        [SIZE_W-1:0] size_type;

   typedef struct packed {
      logic clear;    // zero the accumulator for a new transaction
      logic prod_en;  // operands valid, capture product
      logic acc_en;   // product valid, add into accumulator
   } mac_ctrl_type;

endpackage

FILE: design/memac_req_if.sv
// ----------------------------------------------------------------------------
// memac_req_if
// Request channel: load or compute transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface memac_req_if;
   import memac_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   idx_type   row_index;
   idx_type   col_index;
   value_type element_value;

   modport source (
      output valid, operation, row_index, col_index, element_value,
      input  ready
   );

   modport sink (
      input  valid, operation, row_index, col_index, element_value,
      output ready
   );

endinterface

FILE: design/memac_rsp_if.sv
// ----------------------------------------------------------------------------
// memac_rsp_if
// Response channel: one product element per compute transaction.
// ----------------------------------------------------------------------------
interface memac_rsp_if;
   import memac_pkg::*;

   logic    valid;
   logic    ready;
   idx_type result_row;
   idx_type result_col;
   sum_type dot_sum;
   logic    index_error;

   modport source (
      output valid, result_row, result_col, dot_sum, index_error,
      input  ready
   );

   modport sink (
      input  valid, result_row, result_col, dot_sum, index_error,
      output ready
   );

endinterface

FILE: design/memac_mac_unit.sv
// ----------------------------------------------------------------------------
// memac_mac_unit
// Shared multiply-accumulate: registered product, then running sum.
// ----------------------------------------------------------------------------
module memac_mac_unit #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  memac_pkg::mac_ctrl_type     ctrl,
   input  logic signed [ELEMENT_BITS-1:0] a_data,
   input  logic signed [ELEMENT_BITS-1:0] b_data,
   output memac_pkg::sum_type          acc
);
   import memac_pkg::*;

   localparam int PROD_W = 2 * ELEMENT_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [63:0]       prod_wide;
   sum_type                  acc_ff;
   sum_type                  acc_in;

   assign prod_in   = a_data * b_data;
   assign prod_wide = 64'(prod_ff);

   // sum wraps modulo 2^SUM_W
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + sum_type'(prod_wide[SUM_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: design/matrix_element_multiply_accumulate_core.sv
// ----------------------------------------------------------------------------
// matrix_element_multiply_accumulate_core
// Holds matrices A and B; returns one element of A*B per compute transaction.
// ----------------------------------------------------------------------------
// A load transaction writes one element of A or B and gives no response. A
// compute transaction walks k over the size in use (the CSR size, capped at
// MAX_DIM) through one shared multiplier and adder, one product per cycle.
// After a compute is accepted, ready stays low while the sequencer issues the
// size reads, lets the read, product and accumulate stages drain, and then
// loads the response register. An out-of-range compute skips the reads and
// goes straight to loading the response register. If an earlier response is
// still waiting, the compute stalls in its finish state until the consumer
// takes that response. Each matrix sits in a memory with one registered read
// port, which sets the one product per cycle. The response register lets
// loads and a new compute in while an earlier result waits.
module matrix_element_multiply_accumulate_core #(
   parameter int MAX_DIM      = 64,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  memac_pkg::size_type csr_write_data,
   memac_req_if.sink           req_bus,
   memac_rsp_if.source         rsp_bus
);
   import memac_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int K_W    = $clog2(MAX_DIM + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic signed [ELEMENT_BITS-1:0] left_mem  [DEPTH];
   logic signed [ELEMENT_BITS-1:0] right_mem [DEPTH];

   size_type              size_ff;
   logic [CMP_W-1:0]      size_full;
   logic [CMP_W-1:0]      size_use;
   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [K_W-1:0]        k_ff;
   logic [K_W-1:0]        k_in;
   logic [ADDR_W-1:0]     a_addr_ff;
   logic [ADDR_W-1:0]     a_addr_in;
   logic [ADDR_W-1:0]     b_addr_ff;
   logic [ADDR_W-1:0]     b_addr_in;
   logic [ADDR_W-1:0]     ld_addr;
   logic signed [ELEMENT_BITS-1:0] a_rd_ff;
   logic signed [ELEMENT_BITS-1:0] b_rd_ff;
   logic signed [31:0]    elem_wide;
   logic signed [ELEMENT_BITS-1:0] elem;
   logic                  rd_v_ff;
   logic                  mul_v_ff;
   logic                  accept;
   logic                  in_range;
   logic                  is_load_a;
   logic                  is_load_b;
   logic                  is_compute;
   logic                  last_k;
   logic                  finish_load;
   idx_type               job_row_ff;
   idx_type               job_col_ff;
   logic                  job_err_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   idx_type               rsp_row_ff;
   idx_type               rsp_col_ff;
   sum_type               rsp_sum_ff;
   logic                  rsp_err_ff;
   sum_type               acc;
   mac_ctrl_type          mac_ctrl;

   // size in use saturates at MAX_DIM
   assign size_full = CMP_W'(size_ff);
   assign size_use  = (size_full > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : size_full;

   assign accept     = req_bus.valid & req_bus.ready;
   assign in_range   = (CMP_W'(req_bus.row_index) < size_use) &&
                       (CMP_W'(req_bus.col_index) < size_use);
   assign is_load_a  = accept && (req_bus.operation == OP_LOAD_A) && in_range;
   assign is_load_b  = accept && (req_bus.operation == OP_LOAD_B) && in_range;
   assign is_compute = accept && (req_bus.operation == OP_COMPUTE);

   assign ld_addr   = ADDR_W'(req_bus.row_index * MAX_DIM + req_bus.col_index);
   assign elem_wide = 32'(req_bus.element_value);
   assign elem      = elem_wide[ELEMENT_BITS-1:0];

   assign last_k      = (CMP_W'(k_ff) + CMP_W'(1)) == size_use;
   assign finish_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   assign req_bus.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_compute) begin
               k_in      = '0;
               a_addr_in = ADDR_W'(req_bus.row_index * MAX_DIM);
               b_addr_in = ADDR_W'(req_bus.col_index);
               state_in  = in_range ? ST_ISSUE : ST_FINISH;
            end
         end
         ST_ISSUE: begin
            k_in      = k_ff + K_W'(1);
            a_addr_in = a_addr_ff + ADDR_W'(1);
            b_addr_in = b_addr_ff + ADDR_W'(MAX_DIM);
            if (last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !mul_v_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
         state_ff     <= state_in;
         rd_v_ff      <= (state_ff == ST_ISSUE);
         mul_v_ff     <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      if (is_compute) begin
         job_row_ff <= req_bus.row_index;
         job_col_ff <= req_bus.col_index;
         job_err_ff <= !in_range;
      end
      if (finish_load) begin
         rsp_row_ff <= job_row_ff;
         rsp_col_ff <= job_col_ff;
         rsp_sum_ff <= acc;
         rsp_err_ff <= job_err_ff;
      end
   end

   // matrix memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (is_load_a) begin
         left_mem[ld_addr] <= elem;
      end
      if (state_ff == ST_ISSUE) begin
         a_rd_ff <= left_mem[a_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (is_load_b) begin
         right_mem[ld_addr] <= elem;
      end
      if (state_ff == ST_ISSUE) begin
         b_rd_ff <= right_mem[b_addr_ff];
      end
   end

   assign mac_ctrl.clear   = is_compute;
   assign mac_ctrl.prod_en = rd_v_ff;
   assign mac_ctrl.acc_en  = mul_v_ff;

   memac_mac_unit #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .a_data (a_rd_ff),
      .b_data (b_rd_ff),
      .acc    (acc)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_row  = rsp_row_ff;
   assign rsp_bus.result_col  = rsp_col_ff;
   assign rsp_bus.dot_sum     = rsp_sum_ff;
   assign rsp_bus.index_error = rsp_err_ff;

`ifndef ASSERT_OFF
   a_rd_from_issue: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> $past(state_ff) == ST_ISSUE)
      else $error("read stage valid without an issue cycle");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !rd_v_ff && !mul_v_ff)
      else $error("result captured with products still in flight");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> CMP_W'(k_ff) < size_use)
      else $error("k index beyond size in use");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_sum_ff == '0)
      else $error("index error response with nonzero sum");
`endif

endmodule
